>>> hw/rtl/sspq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sspq_pkg: shared types and codes for the stable sorted priority queue
// Request codes, status codes, controller states and the command struct
// that the controller passes to the datapath.
// ----------------------------------------------------------------------------
package sspq_pkg;

  // Field widths fixed by the word format.
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 5;

  // Request codes carried on the input tuser.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_ENQ  = 2'd0,
    FUNC_DEQ  = 2'd1,
    FUNC_PEEK = 2'd2,
    FUNC_NOP  = 2'd3
  } sspq_func_t;

  // Status codes carried on the output tuser.
  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RSVD  = 2'd3
  } sspq_stat_t;

  // Controller states, one-hot.
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RESP = 2'b10
  } sspq_state_t;

  // Command from controller to datapath.
  typedef struct packed {
    logic       run;
    sspq_func_t func;
  } sspq_cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/sspq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sspq_ctrl: request sequencer
// Takes one request word, issues it to the datapath, and holds the result
// word on the output until it is taken.
// ----------------------------------------------------------------------------
module sspq_ctrl
  import sspq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [FUNC_W-1:0] in_func,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output sspq_cmd_t              cmd
);

  sspq_state_t state_r, state_nxt;

  // Handshake signals follow the state directly.
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_RESP);

  // A request runs in the cycle it is accepted.
  always_comb begin
    cmd.run  = in_tvalid && (state_r == S_IDLE);
    cmd.func = sspq_func_t'(in_func);
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/sspq_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sspq_dp: sorted cell chain and result register
// Each cell holds one value/priority pair and compares its priority with the
// incoming one; an enqueue shifts the tail up by one cell and a dequeue
// shifts the whole chain down by one cell.
// ----------------------------------------------------------------------------
module sspq_dp
  import sspq_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
)
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire sspq_cmd_t                cmd,
  input  wire logic signed [DATA_W-1:0] item_value,
  input  wire logic signed [DATA_W-1:0] item_priority,
  output sspq_stat_t                    res_status,
  output logic signed [DATA_W-1:0]      res_value,
  output logic [COUNT_W-1:0]            res_count,
  output logic                          res_empty
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic signed [DATA_W-1:0] val_r   [CAPACITY];
  logic signed [DATA_W-1:0] pri_r   [CAPACITY];
  logic signed [DATA_W-1:0] val_nxt [CAPACITY];
  logic signed [DATA_W-1:0] pri_nxt [CAPACITY];
  logic [CAPACITY-1:0]      gt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic                     full, empty;
  logic [CNT_W+COUNT_W-1:0] count_ext;

  sspq_stat_t               status_r, status_nxt;
  logic signed [DATA_W-1:0] value_r, value_nxt;

  assign full  = (count_r == CNT_W'(CAPACITY));
  assign empty = (count_r == '0);

  // Per-cell compare and next contents.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] up_val, up_pri, dn_val, dn_pri;
    logic                     prev_le;

    // Cell i is at or past the insert point when it is unused or holds a
    // strictly larger priority; the chain is sorted so this flag is monotone.
    assign gt[i] = (CNT_W'(i) >= count_r) || (pri_r[i] > item_priority);

    if (i == 0) begin : g_head
      assign up_val  = item_value;
      assign up_pri  = item_priority;
      assign prev_le = 1'b1;
    end else begin : g_body
      assign up_val  = val_r[i-1];
      assign up_pri  = pri_r[i-1];
      assign prev_le = !gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign dn_val = val_r[i];
      assign dn_pri = pri_r[i];
    end else begin : g_mid
      assign dn_val = val_r[i+1];
      assign dn_pri = pri_r[i+1];
    end

    always_comb begin
      val_nxt[i] = val_r[i];
      pri_nxt[i] = pri_r[i];
      if (cmd.run) begin
        case (cmd.func)
          FUNC_ENQ: begin
            if (!full && gt[i]) begin
              if (prev_le) begin
                val_nxt[i] = item_value;
                pri_nxt[i] = item_priority;
              end else begin
                val_nxt[i] = up_val;
                pri_nxt[i] = up_pri;
              end
            end
          end
          FUNC_DEQ: begin
            if (!empty) begin
              val_nxt[i] = dn_val;
              pri_nxt[i] = dn_pri;
            end
          end
          default: ;
        endcase
      end
    end

    always_ff @(posedge clk) begin
      val_r[i] <= val_nxt[i];
      pri_r[i] <= pri_nxt[i];
    end
  end

  // Fill count and result word.
  always_comb begin
    count_nxt  = count_r;
    status_nxt = status_r;
    value_nxt  = value_r;
    if (cmd.run) begin
      status_nxt = STAT_OK;
      value_nxt  = '0;
      case (cmd.func)
        FUNC_ENQ: begin
          if (full) status_nxt = STAT_FULL;
          else      count_nxt  = count_r + 1'b1;
        end
        FUNC_DEQ, FUNC_PEEK: begin
          if (empty) begin
            status_nxt = STAT_EMPTY;
          end else begin
            value_nxt = val_r[0];
            if (cmd.func == FUNC_DEQ) count_nxt = count_r - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    value_r  <= value_nxt;
  end

  assign count_ext  = {{COUNT_W{1'b0}}, count_r};
  assign res_status = status_r;
  assign res_value  = value_r;
  assign res_count  = count_ext[COUNT_W-1:0];
  assign res_empty  = empty;

  // The fill count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("sspq_dp: fill count above capacity");

  // A dequeue on a non-empty queue removes exactly one entry.
  a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.run && cmd.func == FUNC_DEQ && !empty) |=> (count_r == $past(count_r) - 1'b1))
    else $error("sspq_dp: dequeue count mismatch");

  // An empty-status result never carries a value.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.run |=> (status_r != STAT_EMPTY || value_r == '0))
    else $error("sspq_dp: empty result with nonzero value");

  // The two front cells stay in priority order.
  a_sorted_front: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CNT_W'(2)) |-> (pri_r[0] <= pri_r[1]))
    else $error("sspq_dp: front cells out of order");

endmodule

`default_nettype wire

>>> hw/rtl/stable_sorted_priority_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue: bounded sorted-list priority queue
// Holds value/priority pairs in ascending priority, equal priorities in
// arrival order; serves enqueue, dequeue and peek requests.
// ----------------------------------------------------------------------------
//  Channel | Dir | Ports                       | Contents
//  --------+-----+-----------------------------+--------------------------------
//  in_     | in  | tvalid tready tuser tdata   | request word: func, value, prio
//  out_    | out | tvalid tready tuser tdata   | result word: status, value,
//          |     |                             | count, empty flag
//
// Each request has an accept cycle, in which the cell chain compares and shifts
// in one step, and then presents its registered result; no new request is
// accepted meanwhile. A stalled result holds the input off until it is taken.
// Synchronous active-low reset empties the queue; cell contents are not
// cleared since only cells below the fill count are ever read.
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue
  import sspq_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
)
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // [31:0] item_value, [63:32] item_priority
  input  wire logic [1:0]  in_tuser,   // [1:0] func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [31:0] out_value, [36:32] entry_count,
                                       // [37] is_empty, [39:38] zero
  output logic [1:0]       out_tuser   // [1:0] status
);

  sspq_cmd_t                cmd;
  sspq_stat_t               res_status;
  logic signed [DATA_W-1:0] res_value;
  logic [COUNT_W-1:0]       res_count;
  logic                     res_empty;

  sspq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_func    (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  sspq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .item_value    (in_tdata[31:0]),
    .item_priority (in_tdata[63:32]),
    .res_status    (res_status),
    .res_value     (res_value),
    .res_count     (res_count),
    .res_empty     (res_empty)
  );

  // Pack the result word.
  assign out_tdata = {2'b00, res_empty, res_count, res_value};
  assign out_tuser = res_status;

endmodule

`default_nettype wire
